[src/rht_pkg.sv]
// ============================================================================
// rht_pkg: shared types and constants for the reference-count hash table
// Item formats, status and opcode codes, table geometry and the address fold.
// ============================================================================
package rht_pkg;

    // Table geometry
    localparam int BUCKETS  = 128;
    localparam int WAYS     = 4;
    localparam int ADDR_W   = 64;
    localparam int COUNT_W  = 32;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Address fold shifts
    localparam int HASH_SH_LO = 2;
    localparam int HASH_SH_HI = 9;

    // Remainder unit: folded address is reduced one byte per cycle
    localparam int DIGIT_W   = 8;
    localparam int NDIGITS   = ADDR_W / DIGIT_W;
    localparam int DIGIT_CW  = $clog2(NDIGITS);

    // Request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_INCREMENTED = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_DECREMENTED = 3'd2,
        ST_FREED       = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_FULL_OR_SAT = 3'd5
    } t_status;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  ref_count;
    } t_rsp;

    // Request after classification: carries its bucket
    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
        logic [BUCKET_W-1:0] bucket;
    } t_job;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   key;
        logic [COUNT_W-1:0]  count;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // (a >> 2) xor (a >> 9), before the reduction to a bucket
    function automatic logic [ADDR_W-1:0] hash_fold(input logic [ADDR_W-1:0] a);
        return (a >> HASH_SH_LO) ^ (a >> HASH_SH_HI);
    endfunction

endpackage

[src/rht_ram.sv]
// ============================================================================
// rht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module rht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rht_front.sv]
// ============================================================================
// rht_front: request intake and bucket classification
// Takes a request, folds its address and reduces it to a bucket number,
// then pushes the classified request into the queue.
// ============================================================================
module rht_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_clearing,
    input  rht_pkg::t_req   i_req,
    input  rht_pkg::t_qstat i_qstat,
    output logic            o_busy,
    output logic            o_push,
    output rht_pkg::t_job   o_job
);
    import rht_pkg::*;

    // Power-of-two bucket count: the bucket is just the low bits
    localparam bit B_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [BUCKET_W:0] BUCKETS_X = (BUCKET_W + 1)'(BUCKETS);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate               r_state, n_state;
    t_opcode               r_opcode, n_opcode;
    logic [ADDR_W-1:0]     r_address, n_address;
    logic [ADDR_W-1:0]     r_x, n_x;
    logic [BUCKET_W-1:0]   r_rem, n_rem;
    logic [DIGIT_CW-1:0]   r_digit, n_digit;

    logic                  accept;
    logic [ADDR_W-1:0]     x_in;
    logic [BUCKET_W-1:0]   rem_step;

    assign o_busy = (r_state != F_IDLE) || i_qstat.full || i_clearing;
    assign accept = i_start && !o_busy;
    assign x_in   = hash_fold(i_req.address);

    // One byte of long division by the bucket count, msb first
    always_comb begin
        logic [BUCKET_W:0]   t;
        logic [BUCKET_W-1:0] r;
        r = r_rem;
        for (int d = 0; d < DIGIT_W; d++) begin
            t = {r, r_x[ADDR_W-1-d]};
            if (t >= BUCKETS_X) begin
                t = t - BUCKETS_X;
            end
            r = t[BUCKET_W-1:0];
        end
        rem_step = r;
    end

    // Intake control
    always_comb begin
        n_state   = r_state;
        n_opcode  = r_opcode;
        n_address = r_address;
        n_x       = r_x;
        n_rem     = r_rem;
        n_digit   = r_digit;
        o_push    = 1'b0;
        o_job     = '{opcode: r_opcode, address: r_address, bucket: r_rem};
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (B_POW2) begin
                        o_push = 1'b1;
                        o_job  = '{opcode: i_req.opcode, address: i_req.address,
                                   bucket: x_in[BUCKET_W-1:0]};
                    end else begin
                        n_state   = F_HASH;
                        n_opcode  = i_req.opcode;
                        n_address = i_req.address;
                        n_x       = x_in;
                        n_rem     = '0;
                        n_digit   = '0;
                    end
                end
            end
            F_HASH: begin
                n_rem   = rem_step;
                n_x     = r_x << DIGIT_W;
                n_digit = r_digit + DIGIT_CW'(1);
                if (r_digit == DIGIT_CW'(NDIGITS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode  <= n_opcode;
        r_address <= n_address;
        r_x       <= n_x;
        r_rem     <= n_rem;
        r_digit   <= n_digit;
    end

endmodule

[src/rht_queue.sv]
// ============================================================================
// rht_queue: short request queue
// Decouples classification from table update.
// ============================================================================
module rht_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rht_pkg::t_job    i_job,
    input  logic             i_pop,
    output rht_pkg::t_job    o_job,
    output rht_pkg::t_qstat  o_qstat
);
    import rht_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr, n_wptr;
    logic [QAW-1:0]   r_rptr, n_rptr;
    logic [QAW:0]     r_count, n_count;

    assign o_job         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == (QAW + 1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    // Pointer and fill update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + QAW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + QAW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (QAW + 1)'(1);
            2'b01:   n_count = r_count - (QAW + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[src/rht_back.sv]
// ============================================================================
// rht_back: table update engine
// Clears the table after reset, then reads one bucket row per request,
// matches its ways, writes the row back and issues the response.
// ============================================================================
module rht_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rht_pkg::t_qstat i_qstat,
    input  rht_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_clearing,
    output logic            o_valid,
    output rht_pkg::t_rsp   o_rsp
);
    import rht_pkg::*;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } t_bstate;

    t_bstate              r_state, n_state;
    logic [BUCKET_W-1:0]  r_clr, n_clr;
    t_job                 r_job;
    logic                 r_valid, n_valid;
    t_rsp                 r_rsp, n_rsp;

    logic                 ram_we, ram_re;
    logic [BUCKET_W-1:0]  ram_waddr, ram_raddr;
    logic [ROW_W-1:0]     ram_wdata, ram_rdata;

    t_row                 row, new_row;
    t_rsp                 rsp_calc;
    logic                 hit, free;
    logic [WAY_W-1:0]     hit_idx, free_idx;
    logic [COUNT_W-1:0]   cur_count;

    rht_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign row        = t_row'(ram_rdata);
    assign o_clearing = (r_state == B_CLEAR);
    assign o_valid    = r_valid;
    assign o_rsp      = r_rsp;

    // Way match and lowest free way
    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (row[w].valid) begin
                if (!hit && row[w].key == r_job.address) begin
                    hit     = 1'b1;
                    hit_idx = WAY_W'(w);
                end
            end else if (!free) begin
                free     = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
        cur_count = row[hit_idx].count;
    end

    // Count update and response
    always_comb begin
        new_row  = row;
        rsp_calc = '{status: ST_NOT_FOUND, ref_count: '0};
        if (r_job.opcode == OP_ADD) begin
            if (hit) begin
                if (cur_count == COUNT_MAX) begin
                    rsp_calc = '{status: ST_FULL_OR_SAT, ref_count: COUNT_MAX};
                end else begin
                    new_row[hit_idx].count = cur_count + COUNT_W'(1);
                    rsp_calc = '{status: ST_INCREMENTED,
                                 ref_count: cur_count + COUNT_W'(1)};
                end
            end else if (free) begin
                new_row[free_idx] = '{valid: 1'b1, key: r_job.address,
                                      count: COUNT_W'(1)};
                rsp_calc = '{status: ST_INSERTED, ref_count: COUNT_W'(1)};
            end else begin
                rsp_calc = '{status: ST_FULL_OR_SAT, ref_count: '0};
            end
        end else begin
            if (hit) begin
                if (cur_count <= COUNT_W'(1)) begin
                    new_row[hit_idx].valid = 1'b0;
                    new_row[hit_idx].count = '0;
                    rsp_calc = '{status: ST_FREED, ref_count: '0};
                end else begin
                    new_row[hit_idx].count = cur_count - COUNT_W'(1);
                    rsp_calc = '{status: ST_DECREMENTED,
                                 ref_count: cur_count - COUNT_W'(1)};
                end
            end else begin
                rsp_calc = '{status: ST_NOT_FOUND, ref_count: '0};
            end
        end
    end

    // Sequencer: clearing pass, row read, update and write back
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        o_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = i_job.bucket;
        ram_waddr = r_job.bucket;
        ram_wdata = ROW_W'(new_row);
        unique case (r_state)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + BUCKET_W'(1);
                if (r_clr == BUCKET_W'(BUCKETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    ram_re  = 1'b1;
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                ram_we  = 1'b1;
                n_valid = 1'b1;
                n_rsp   = rsp_calc;
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (o_pop) begin
            r_job <= i_job;
        end
    end

`ifndef SYNTHESIS
    // Only take a request that is actually queued
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_qstat.empty)
        else $error("pop from empty queue");

    // An update always follows a row read of a popped request
    a_exec_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EXEC) |-> $past(o_pop))
        else $error("update without a row read");

    // Write back goes to the row that was read
    a_wb_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EXEC) |-> (ram_waddr == $past(ram_raddr)))
        else $error("write back to wrong row");

    // A response only comes out of an update cycle
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == B_EXEC))
        else $error("response without update");
`endif

endmodule

[src/refcount_hash_table_core.sv]
// ============================================================================
// refcount_hash_table_core: reference-count hash table
// Maps an object address to a reference count; add and remove requests.
// ============================================================================
//
//  channel   | ports                  | handshake
//  ----------+------------------------+------------------------------------
//  request   | start, busy, i_req     | taken when start high and busy low
//  response  | o_valid, o_rsp         | one-cycle strobe, cannot be held off
//
//  After reset a clearing pass writes every bucket row, with busy high.
//  For each request the update engine first reads one row from the
//  bucket RAM, then matches, updates the count and writes the row back.
//  With a power-of-two bucket count the bucket is found at intake;
//  otherwise the remainder unit reduces NDIGITS (8) bytes per request.
//  A two-entry queue lets intake run ahead; busy rises when it is full.
//  The response leaves from a register, in the cycle after its update.
//
module refcount_hash_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rht_pkg::t_req i_req,
    output logic          o_valid,
    output rht_pkg::t_rsp o_rsp
);
    import rht_pkg::*;

    t_qstat qstat;
    t_job   push_job, head_job;
    logic   push, pop, clearing;

    rht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_clearing (clearing),
        .i_req      (i_req),
        .i_qstat    (qstat),
        .o_busy     (busy),
        .o_push     (push),
        .o_job      (push_job)
    );

    rht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    rht_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

endmodule

[tb/sv/tb_top.sv]
// ============================================================================
// tb_top: regression bench for refcount_hash_table_core
// Drives add and remove requests through the start/busy handshake and keeps
// a shadow copy of the bucket table. Every response strobe is compared field
// by field with the oldest predicted response. Directed cases come first,
// then three phases of random traffic aimed at a few crowded buckets.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rht_pkg::*;

    localparam int TABLE_SIZE     = BUCKETS * WAYS;
    localparam int HOT_BUCKETS    = 6;
    localparam int HOT_PER_BUCKET = WAYS + 2;   // more keys than ways, so buckets fill
    localparam int HOT_SET        = HOT_BUCKETS * HOT_PER_BUCKET;
    localparam int PHASE_REQS     = 310;
    localparam int WATCHDOG_LIMIT = 2000;      // covers the clearing pass after reset
    localparam int TAIL_CYCLES    = 40;
    localparam int REPORT_MAX     = 10;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_valid;
    t_rsp  o_rsp;

    // Shadow of the bucket table
    bit                 shadow_valid [TABLE_SIZE];
    logic [ADDR_W-1:0]  shadow_key   [TABLE_SIZE];
    logic [COUNT_W-1:0] shadow_count [TABLE_SIZE];

    t_rsp awaited_rsp[$];
    int   mismatch_cnt;
    int   sender_idle_pct;
    int   quiet_cycles;

    refcount_hash_table_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the response it causes
    function automatic t_rsp apply_table_op(input t_req rq);
        int   base;
        int   hit;
        int   free_w;
        int   idx;
        t_rsp r;
        base   = int'(((rq.address >> HASH_SH_LO) ^ (rq.address >> HASH_SH_HI)) % BUCKETS)
                 * WAYS;
        hit    = -1;
        free_w = -1;
        r.status    = ST_NOT_FOUND;
        r.ref_count = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (shadow_valid[base + w]) begin
                if (hit < 0 && shadow_key[base + w] == rq.address)
                    hit = w;
            end else if (free_w < 0) begin
                free_w = w;
            end
        end
        if (rq.opcode == OP_ADD) begin
            if (hit >= 0) begin
                idx = base + hit;
                if (shadow_count[idx] == COUNT_MAX) begin
                    r.status = ST_FULL_OR_SAT;
                end else begin
                    shadow_count[idx] = shadow_count[idx] + 1'b1;
                    r.status = ST_INCREMENTED;
                end
                r.ref_count = shadow_count[idx];
            end else if (free_w >= 0) begin
                idx = base + free_w;
                shadow_valid[idx] = 1'b1;
                shadow_key[idx]   = rq.address;
                shadow_count[idx] = 1;
                r.status    = ST_INSERTED;
                r.ref_count = 1;
            end else begin
                r.status = ST_FULL_OR_SAT;
            end
        end else if (hit >= 0) begin
            idx = base + hit;
            if (shadow_count[idx] <= 1) begin
                shadow_valid[idx] = 1'b0;
                shadow_count[idx] = '0;
                r.status = ST_FREED;
            end else begin
                shadow_count[idx] = shadow_count[idx] - 1'b1;
                r.status    = ST_DECREMENTED;
                r.ref_count = shadow_count[idx];
            end
        end
        return r;
    endfunction

    // Random address that folds into the given bucket (power-of-two bucket count)
    function automatic logic [ADDR_W-1:0] addr_in_bucket(input logic [BUCKET_W-1:0] bkt);
        logic [ADDR_W-1:0] a;
        a = {$urandom, $urandom};
        a[HASH_SH_LO +: BUCKET_W] = bkt ^ a[HASH_SH_HI +: BUCKET_W];
        return a;
    endfunction

    // Issue one request; returns at the edge that accepts it.
    // start is left high, so back-to-back requests keep it up.
    task automatic send_req(input t_opcode op, input logic [ADDR_W-1:0] addr);
        t_req rq;
        rq.opcode  = op;
        rq.address = addr;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            i_req <= {1'($urandom), $urandom, $urandom};
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        awaited_rsp.push_back(apply_table_op(rq));
    endtask

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                   input logic [ADDR_W-1:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // One address through its whole life, low and high extremes of the key
    task automatic test_single_address();
        send_req(OP_REMOVE, '0);
        send_req(OP_ADD, '0);
        send_req(OP_ADD, '0);
        send_req(OP_REMOVE, '0);
        send_req(OP_REMOVE, '0);
        send_req(OP_REMOVE, '0);
        send_req(OP_ADD, '1);
        send_req(OP_REMOVE, '1);
    endtask

    // Fill one bucket, overflow it, free a way and refill it.
    // A saturated count needs 2^32 adds and is out of reach here.
    task automatic test_bucket_overflow();
        logic [BUCKET_W-1:0] bkt;
        logic [ADDR_W-1:0]   keys [WAYS+1];
        bkt = BUCKET_W'($urandom);
        for (int k = 0; k <= WAYS; k++)
            keys[k] = addr_in_bucket(bkt);
        for (int k = 0; k <= WAYS; k++)
            send_req(OP_ADD, keys[k]);
        // same bucket, key differs only in the top bit
        send_req(OP_ADD, keys[0] ^ (64'd1 << (ADDR_W - 1)));
        send_req(OP_ADD, keys[0]);
        send_req(OP_REMOVE, keys[WAYS > 1 ? 1 : 0]);
        send_req(OP_ADD, keys[WAYS]);
        send_req(OP_ADD, keys[0] ^ 64'd1);
    endtask

    // Random traffic concentrated on a few buckets, plus noise
    task automatic test_random_traffic(input int idle_pct, input int n_req);
        logic [ADDR_W-1:0]   hot_addr [HOT_SET];
        logic [ADDR_W-1:0]   addr;
        logic [BUCKET_W-1:0] bkt;
        int                  sel;
        sender_idle_pct = idle_pct;
        for (int b = 0; b < HOT_BUCKETS; b++) begin
            bkt = BUCKET_W'($urandom);
            for (int k = 0; k < HOT_PER_BUCKET; k++)
                hot_addr[b * HOT_PER_BUCKET + k] = addr_in_bucket(bkt);
        end
        for (int n = 0; n < n_req; n++) begin
            sel  = $urandom_range(99);
            addr = hot_addr[$urandom_range(HOT_SET - 1)];
            if (sel < 42)
                send_req(OP_ADD, addr);
            else if (sel < 74)
                send_req(OP_REMOVE, addr);
            else if (sel < 86)
                send_req(t_opcode'($urandom_range(1)), {$urandom, $urandom});
            else
                send_req(t_opcode'($urandom_range(1)),
                         addr ^ (64'd1 << $urandom_range(ADDR_W - 1)));
        end
    endtask

    // Response checker: each strobe against the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (awaited_rsp.size() == 0) begin
                report_mismatch("unexpected response", '0, ADDR_W'(o_rsp));
            end else begin
                want = awaited_rsp.pop_front();
                if (o_valid !== 1'b1)
                    report_mismatch("o_valid", ADDR_W'(1'b1), ADDR_W'(o_valid));
                if (o_rsp.status !== want.status)
                    report_mismatch("status", ADDR_W'(want.status), ADDR_W'(o_rsp.status));
                if (o_rsp.ref_count !== want.ref_count)
                    report_mismatch("ref_count", ADDR_W'(want.ref_count),
                                    ADDR_W'(o_rsp.ref_count));
            end
        end
    end

    // Watchdog: cycles with neither a request taken nor a response seen
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatch_cnt    = 0;
        quiet_cycles    = 0;
        sender_idle_pct = 18;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_address();
        test_bucket_overflow();
        test_random_traffic(18, PHASE_REQS);
        test_random_traffic(62, PHASE_REQS);
        test_random_traffic(0, PHASE_REQS);

        start <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && awaited_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
